// ----- hw/rtl/cdq_pkg.sv -----
// shared types and constants for the circular deque
// used by the interfaces, the store and the top level
package cdq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_REAR  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_REAR   = 2'd2,
    MODE_POP_FRONT  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// ----- hw/rtl/cdq_if.sv -----
// valid/ready channel interfaces for requests and responses
// depends on cdq_pkg
interface cdq_req_if;
  logic                               valid;
  logic                               ready;
  logic [cdq_pkg::ModeW-1:0]          mode;
  logic signed [cdq_pkg::DataW-1:0]   push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [cdq_pkg::StatusW-1:0]        status;
  logic signed [cdq_pkg::DataW-1:0]   pop_value;
  logic [cdq_pkg::OccW-1:0]           occupancy;

  modport source (output valid, output status, output pop_value, output occupancy,
                  input ready);
  modport sink (input valid, input status, input pop_value, input occupancy,
                output ready);
endinterface

// ----- hw/rtl/cdq_store.sv -----
// word store of the deque: one write and one registered read port
// depends on cdq_pkg
module cdq_store #(
  parameter int unsigned Depth = cdq_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(Depth)-1:0]            waddr_i,
  input  logic signed [cdq_pkg::DataW-1:0]    wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(Depth)-1:0]            raddr_i,
  output logic signed [cdq_pkg::DataW-1:0]    rdata_o
);

  logic signed [cdq_pkg::DataW-1:0] mem [Depth];
  logic signed [cdq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/circular_deque_top.sv -----
// circular deque of signed words: pointer and count control around the word store
// depends on cdq_pkg, cdq_req_if, cdq_rsp_if and cdq_store
// push, overflow and underflow results appear in the cycle after acceptance;
//   a pop result goes via the store's read register, then the response register
// one push per cycle while the response register is free; a pop holds off requests
//   until its result is loaded; a result waiting on rsp_o.ready blocks the next word
// reset: head, tail and count go to zero; store contents stay undefined, no clearing
module circular_deque_top #(
  parameter int unsigned Depth = cdq_pkg::DefaultDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  cdq_req_if.sink    req_i,
  cdq_rsp_if.source  rsp_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cdq_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic                              out_valid_q;
  logic [cdq_pkg::StatusW-1:0]       out_status_q, out_status_d;
  logic signed [cdq_pkg::DataW-1:0]  out_value_q, out_value_d;
  logic [cdq_pkg::OccW-1:0]          out_occ_q, out_occ_d;
  logic                              out_load;

  logic                              mem_we, mem_re;
  logic [AddrW-1:0]                  mem_waddr, mem_raddr;
  logic signed [cdq_pkg::DataW-1:0]  mem_rdata;

  logic            accept, out_free, is_full, is_empty;
  cdq_pkg::mode_e  mode;
  logic [31:0]     cnt_ext;

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] idx);
    return (idx == AddrW'(Depth - 1)) ? '0 : idx + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] wrap_dec(input logic [AddrW-1:0] idx);
    return (idx == '0) ? AddrW'(Depth - 1) : idx - AddrW'(1);
  endfunction

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == cdq_pkg::S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign mode        = cdq_pkg::mode_e'(req_i.mode);
  assign is_full     = (cnt_q == CntW'(Depth));
  assign is_empty    = (cnt_q == '0);
  assign cnt_ext     = 32'(cnt_d);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_re      = 1'b0;
    mem_raddr   = tail_q;
    out_load    = 1'b0;
    out_status_d = cdq_pkg::STAT_DONE;
    out_value_d  = '0;
    case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          if (mode inside {cdq_pkg::MODE_PUSH_REAR, cdq_pkg::MODE_PUSH_FRONT}) begin
            out_load = 1'b1;
            if (is_full) begin
              out_status_d = cdq_pkg::STAT_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CntW'(1);
              if (is_empty) begin
                head_d    = '0;
                tail_d    = '0;
                mem_waddr = '0;
              end else if (mode == cdq_pkg::MODE_PUSH_REAR) begin
                tail_d    = wrap_inc(tail_q);
                mem_waddr = tail_d;
              end else begin
                head_d    = wrap_dec(head_q);
                mem_waddr = head_d;
              end
            end
          end else begin
            if (is_empty) begin
              out_load     = 1'b1;
              out_status_d = cdq_pkg::STAT_UNDERFLOW;
            end else begin
              mem_re  = 1'b1;
              state_d = cdq_pkg::S_READ;
              cnt_d   = cnt_q - CntW'(1);
              if (mode == cdq_pkg::MODE_POP_REAR) begin
                mem_raddr = tail_q;
              end else begin
                mem_raddr = head_q;
              end
              if (cnt_q == CntW'(1)) begin
                head_d = '0;
                tail_d = '0;
              end else if (mode == cdq_pkg::MODE_POP_REAR) begin
                tail_d = wrap_dec(tail_q);
              end else begin
                head_d = wrap_inc(head_q);
              end
            end
          end
        end
      end
      cdq_pkg::S_READ: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = mem_rdata;
          state_d     = cdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
    out_occ_d = cnt_ext[cdq_pkg::OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_occ_q    <= out_occ_d;
    end
  end

  cdq_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.push_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.pop_value = out_value_q;
  assign rsp_o.occupancy = out_occ_q;

endmodule

// ----- bench/tb_circular_deque_top.sv -----
`timescale 1ns / 1ps
// testbench for circular_deque_top: directed and random push/pop words on the request channel
// a scoreboard class predicts every response; depends on cdq_pkg, cdq_req_if and cdq_rsp_if

class deque_scoreboard;

  typedef struct {
    cdq_pkg::status_e                status;
    logic signed [cdq_pkg::DataW-1:0] pop_value;
    logic [cdq_pkg::OccW-1:0]        occupancy;
  } deque_rsp_t;

  logic signed [cdq_pkg::DataW-1:0] slots[];
  int unsigned depth;
  int unsigned head;
  int unsigned tail;
  int unsigned fill;
  int unsigned errors;
  deque_rsp_t expected_q[$];

  function new(int unsigned depth_in);
    depth = depth_in;
    slots = new[depth_in];
    head = 0;
    tail = 0;
    fill = 0;
    errors = 0;
  endfunction

  function void note_request(cdq_pkg::mode_e mode, logic signed [cdq_pkg::DataW-1:0] value);
    deque_rsp_t exp_rsp;
    exp_rsp.status = cdq_pkg::STAT_DONE;
    exp_rsp.pop_value = '0;
    if (mode inside {cdq_pkg::MODE_PUSH_REAR, cdq_pkg::MODE_PUSH_FRONT}) begin
      if (fill >= depth) begin
        exp_rsp.status = cdq_pkg::STAT_OVERFLOW;
      end else begin
        if (fill == 0) begin
          head = 0;
          tail = 0;
          slots[0] = value;
        end else if (mode == cdq_pkg::MODE_PUSH_REAR) begin
          tail = (tail + 1) % depth;
          slots[tail] = value;
        end else begin
          head = (head + depth - 1) % depth;
          slots[head] = value;
        end
        fill++;
      end
    end else begin
      if (fill == 0) begin
        exp_rsp.status = cdq_pkg::STAT_UNDERFLOW;
      end else begin
        exp_rsp.pop_value = (mode == cdq_pkg::MODE_POP_REAR) ? slots[tail] : slots[head];
        if (fill == 1) begin
          head = 0;
          tail = 0;
        end else if (mode == cdq_pkg::MODE_POP_REAR) begin
          tail = (tail + depth - 1) % depth;
        end else begin
          head = (head + 1) % depth;
        end
        fill--;
      end
    end
    exp_rsp.occupancy = cdq_pkg::OccW'(fill);
    expected_q.push_back(exp_rsp);
  endfunction

  function void check_result(logic [cdq_pkg::StatusW-1:0] status,
                             logic signed [cdq_pkg::DataW-1:0] pop_value,
                             logic [cdq_pkg::OccW-1:0] occupancy);
    deque_rsp_t exp_rsp;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected response word, status %0d pop_value %0d occupancy %0d",
               $time, status, pop_value, occupancy);
      return;
    end
    exp_rsp = expected_q.pop_front();
    if (status !== exp_rsp.status) begin
      errors++;
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp_rsp.status, status);
    end
    if (pop_value !== exp_rsp.pop_value) begin
      errors++;
      $display("%0t: pop_value mismatch, expected %0d, actual %0d",
               $time, exp_rsp.pop_value, pop_value);
    end
    if (occupancy !== exp_rsp.occupancy) begin
      errors++;
      $display("%0t: occupancy mismatch, expected %0d, actual %0d",
               $time, exp_rsp.occupancy, occupancy);
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void check_drained();
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d response words never arrived, expected status %0d occupancy %0d",
               $time, expected_q.size(), expected_q[0].status, expected_q[0].occupancy);
    end
  endfunction

endclass

module tb_circular_deque_top;

  localparam int unsigned Depth = cdq_pkg::DefaultDepth;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned NumPhases = 13;

  logic clk;
  logic rst_n;

  bit req_idle_on;
  bit rsp_idle_on;
  bit hold_rsp;

  deque_scoreboard deque_sb;

  cdq_req_if req_if ();
  cdq_rsp_if rsp_if ();

  circular_deque_top #(
    .Depth(Depth)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [cdq_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // push_pct: chance of a push in percent, the rest are pops
  function automatic cdq_pkg::mode_e pick_mode(int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? cdq_pkg::MODE_PUSH_FRONT : cdq_pkg::MODE_PUSH_REAR;
    end
    return $urandom_range(0, 1) ? cdq_pkg::MODE_POP_FRONT : cdq_pkg::MODE_POP_REAR;
  endfunction

  task automatic send_word(input cdq_pkg::mode_e mode,
                           input logic signed [cdq_pkg::DataW-1:0] value);
    if (req_idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.push_value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    deque_sb.note_request(mode, value);
  endtask

  task automatic take_edge();
    @(posedge clk);
    if (rsp_if.valid && rsp_if.ready) begin
      deque_sb.check_result(rsp_if.status, rsp_if.pop_value, rsp_if.occupancy);
    end
  endtask

  // response side
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) take_edge();
        hold_rsp = 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) take_edge();
      end else begin
        rsp_if.ready <= 1'b1;
        take_edge();
      end
    end
  end

  // stall watchdog
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("circular_deque_top test failed");
    $finish;
  end

  initial begin
    int unsigned push_pct;
    req_if.valid <= 1'b0;
    req_if.mode <= cdq_pkg::MODE_PUSH_REAR;
    req_if.push_value <= '0;
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    hold_rsp = 1'b0;
    deque_sb = new(Depth);
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // underflow at both ends, single-element pushes and pops, extremes
    send_word(cdq_pkg::MODE_POP_REAR, 32'sh12345678);
    send_word(cdq_pkg::MODE_POP_FRONT, -32'sd1);
    send_word(cdq_pkg::MODE_PUSH_REAR, 32'sh7fffffff);
    send_word(cdq_pkg::MODE_POP_REAR, '0);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'sh80000000);
    send_word(cdq_pkg::MODE_POP_FRONT, '0);
    send_word(cdq_pkg::MODE_PUSH_FRONT, -32'sd1);
    send_word(cdq_pkg::MODE_PUSH_REAR, '0);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'sh55555555);
    send_word(cdq_pkg::MODE_PUSH_REAR, 32'shaaaaaaaa);
    send_word(cdq_pkg::MODE_POP_FRONT, '0);
    send_word(cdq_pkg::MODE_POP_REAR, '0);
    send_word(cdq_pkg::MODE_POP_REAR, '0);
    send_word(cdq_pkg::MODE_POP_FRONT, '0);
    send_word(cdq_pkg::MODE_POP_FRONT, '0);
    send_word(cdq_pkg::MODE_POP_REAR, '0);

    // random phases: fill, mix, drain in turn
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase % 3)
        0: push_pct = 80;
        1: push_pct = 50;
        default: push_pct = 20;
      endcase
      req_idle_on = (phase < NumPhases - 2) && (phase % 4 != 3);
      rsp_idle_on = (phase < NumPhases - 2) && (phase % 5 != 4);
      if (phase == 3) begin
        push_pct = 90;
        req_idle_on = 1'b0;
        hold_rsp = 1'b1;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_word(pick_mode(push_pct), pick_value());
      end
    end
    req_if.valid <= 1'b0;

    while (deque_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    deque_sb.check_drained();
    if (deque_sb.errors == 0) begin
      $display("circular_deque_top test passed");
    end else begin
      $display("circular_deque_top test failed");
    end
    $finish;
  end

endmodule
